>>> rtl/tbsa_pkg.sv
package tbsa_pkg;

    localparam int GRID_SIDE_DEF = 20;
    localparam int BIN_TOTAL_DEF = 400;

    localparam int COORD_W     = 16;
    localparam int PHOTON_W    = 24;
    localparam int BIN_W       = 9;
    localparam int MEAN_W      = 32;
    localparam int MEAN_FRAC_W = 8;
    localparam int HITS_W      = 24;
    localparam int SUM_W       = 48;
    localparam int OUTCOME_W   = 2;
    localparam int HALF_W      = 15;
    localparam int BWID_W      = 15;
    localparam int OFFSQ_W     = 35;
    localparam int CFG_DATA_W  = 35;
    localparam int CFG_INDEX_W = 2;

    localparam logic [HALF_W-1:0]  HALF_EXTENT_RST   = 15'd1280;
    localparam logic [BWID_W-1:0]  BIN_WIDTH_RST     = 15'd128;
    localparam logic [OFFSQ_W-1:0] MAX_OFFSET_SQ_RST = 35'd16384;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_EXTENT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OFFSET_SQ = 2'd2;

    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_OK,
        OUT_NO_TRACK,
        OUT_TOO_STEEP,
        OUT_OUTSIDE
    } outcome_t;

endpackage

>>> rtl/track_binned_signal_averager_top.sv
// Binned mean profile of detector light over a square surface grid.
// The s_ channel takes one beat per item: an event (s_kind 0) with two tracker
// hits and a photon count, or a query (s_kind 1) for the bin in s_query_bin.
// Every item gives exactly one beat on the m_ channel: the outcome code, the
// bin index, the bin mean in Q.8 and the bin hit count.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while no item is in flight; the block does not enforce it.
// Items are worked one at a time. An accepted event passes the calculation, test,
// bin-index division, load and (if needed) mean division steps; a query starts
// at the load step and an event rejected at the test step goes straight to its
// result. The next beat can be taken in the cycle after the result is registered.
// The longest steps are the bit-serial mean divider (one quotient bit a cycle,
// 32 bits) and two bin-index dividers (one quotient bit a cycle each, in parallel).
// The bin sums and hit counts live in one single-port-write memory that is
// read, updated and written back once per accepted event.
// After reset the block sweeps the memory to zero, one bin a cycle, over all
// BIN_TOTAL bins, and accepts no item during that sweep.
// One finished result waits in the output register while the next item is
// accepted and worked; that item then holds in its last step until the
// receiver takes the waiting beat.
module track_binned_signal_averager_top #(
    parameter int GRID_SIDE = tbsa_pkg::GRID_SIDE_DEF,
    parameter int BIN_TOTAL = tbsa_pkg::BIN_TOTAL_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [tbsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tbsa_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [tbsa_pkg::COORD_W-1:0]  s_near_x,
    input  logic signed [tbsa_pkg::COORD_W-1:0]  s_near_z,
    input  logic signed [tbsa_pkg::COORD_W-1:0]  s_far_x,
    input  logic signed [tbsa_pkg::COORD_W-1:0]  s_far_z,
    input  logic [tbsa_pkg::PHOTON_W-1:0]        s_photons,
    input  logic [tbsa_pkg::BIN_W-1:0]           s_query_bin,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tbsa_pkg::OUTCOME_W-1:0]       m_outcome,
    output logic [tbsa_pkg::BIN_W-1:0]           m_bin_index,
    output logic [tbsa_pkg::MEAN_W-1:0]          m_mean_q8,
    output logic [tbsa_pkg::HITS_W-1:0]          m_hit_count
);

    import tbsa_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int QW    = CW + 1;
    localparam int CNTW  = $clog2(CW + 1);
    localparam int IW    = 2 * CW;
    localparam int AW    = $clog2(BIN_TOTAL + 1);
    localparam int AMW   = $clog2(BIN_TOTAL);
    localparam int CMPW0 = (IW > BIN_W) ? IW : BIN_W;
    localparam int CMPW  = (CMPW0 > AW) ? CMPW0 : AW;
    localparam int PW    = 23;
    localparam int NUMW  = 21;
    localparam int W20W  = 20;
    localparam int DIVW  = NUMW + CW;
    localparam int MW    = SUM_W + MEAN_FRAC_W;
    localparam int DSHW  = HITS_W + MEAN_W - 1;
    localparam int MCW   = $clog2(MEAN_W);
    localparam int ENTW  = SUM_W + HITS_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_TEST,
        ST_DIV,
        ST_INDEX,
        ST_LOAD,
        ST_MSETUP,
        ST_MDIV,
        ST_FINISH
    } state_t;

    state_t                   state_reg;

    logic [HALF_W-1:0]        half_extent_reg;
    logic [BWID_W-1:0]        bin_width_reg;
    logic [OFFSQ_W-1:0]       max_offset_sq_reg;

    logic                     kind_reg;
    logic signed [COORD_W-1:0] near_x_reg;
    logic signed [COORD_W-1:0] near_z_reg;
    logic signed [COORD_W-1:0] far_x_reg;
    logic signed [COORD_W-1:0] far_z_reg;
    logic [PHOTON_W-1:0]      photons_reg;

    logic [AMW-1:0]           clr_cnt_reg;
    logic                     zero_reg;
    logic [31:0]              sqx_reg;
    logic [31:0]              sqz_reg;
    logic signed [PW-1:0]     px_reg;
    logic signed [PW-1:0]     pz_reg;

    logic [DIVW-1:0]          rrow_reg;
    logic [DIVW-1:0]          rcol_reg;
    logic [DIVW-1:0]          wsh_reg;
    logic [QW-1:0]            qrow_reg;
    logic [QW-1:0]            qcol_reg;
    logic                     colz_reg;
    logic [CNTW-1:0]          cnt_reg;

    logic [AMW-1:0]           idx_reg;
    outcome_t                 res_outcome_reg;
    logic [BIN_W-1:0]         res_bin_reg;
    logic [MEAN_W-1:0]        res_mean_reg;
    logic [HITS_W-1:0]        res_hits_reg;

    logic [SUM_W-1:0]         sum_reg;
    logic [HITS_W-1:0]        hits_reg;
    logic [MW-1:0]            rem_reg;
    logic [DSHW-1:0]          dsh_reg;
    logic [MCW-1:0]           mcnt_reg;

    logic                     m_valid_reg;
    logic [OUTCOME_W-1:0]     m_outcome_reg;
    logic [BIN_W-1:0]         m_bin_index_reg;
    logic [MEAN_W-1:0]        m_mean_q8_reg;
    logic [HITS_W-1:0]        m_hit_count_reg;

    logic [ENTW-1:0]          mem [BIN_TOTAL];
    logic [ENTW-1:0]          mem_q_reg;
    logic                     mem_we;
    logic [AMW-1:0]           mem_waddr;
    logic [ENTW-1:0]          mem_wdata;
    logic                     rd_en;
    logic [AMW-1:0]           rd_addr;

    logic [W20W-1:0]          lim_w;
    logic [BWID_W-1:0]        bw_eff;
    logic [W20W-1:0]          w20;
    logic signed [PW-1:0]     lim_s;
    logic signed [PW-1:0]     fx_e;
    logic signed [PW-1:0]     fz_e;
    logic signed [PW-1:0]     nx_e;
    logic signed [PW-1:0]     nz_e;
    logic signed [PW-1:0]     px_n;
    logic signed [PW-1:0]     pz_n;
    logic signed [COORD_W:0]  dx;
    logic signed [COORD_W:0]  dz;
    logic signed [33:0]       sqx_full;
    logic signed [33:0]       sqz_full;
    logic [32:0]              sq_sum;
    logic                     outside;
    logic signed [PW-1:0]     ar;
    logic signed [PW-1:0]     ac;
    logic [NUMW-1:0]          ac_m1;
    logic                     row_ge;
    logic                     col_ge;
    logic [CW-1:0]            row_c;
    logic [CW-1:0]            col_c;
    logic [CMPW-1:0]          idx_full;
    logic                     idx_ok;
    logic [CMPW-1:0]          qext;
    logic                     q_ok;
    logic [SUM_W-1:0]         mem_sum;
    logic [HITS_W-1:0]        mem_hits;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_next;
    logic [HITS_W-1:0]        hits_next;
    logic                     m_ge;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_mean_q8   = m_mean_q8_reg;
    assign m_hit_count = m_hit_count_reg;

    // Limit and bin width are both scaled by 20 to match the scaled surface point.
    assign lim_w  = {1'b0, half_extent_reg, 4'b0} + {3'b0, half_extent_reg, 2'b0};
    assign bw_eff = (bin_width_reg == '0) ? BWID_W'(1) : bin_width_reg;
    assign w20    = {1'b0, bw_eff, 4'b0} + {3'b0, bw_eff, 2'b0};
    assign lim_s  = signed'({{(PW-W20W){1'b0}}, lim_w});

    assign fx_e = signed'({{(PW-COORD_W){far_x_reg[COORD_W-1]}}, far_x_reg});
    assign fz_e = signed'({{(PW-COORD_W){far_z_reg[COORD_W-1]}}, far_z_reg});
    assign nx_e = signed'({{(PW-COORD_W){near_x_reg[COORD_W-1]}}, near_x_reg});
    assign nz_e = signed'({{(PW-COORD_W){near_z_reg[COORD_W-1]}}, near_z_reg});
    assign px_n = (fx_e <<< 5) - (fx_e <<< 2) - fx_e - ((nx_e <<< 3) - nx_e);
    assign pz_n = (fz_e <<< 5) - (fz_e <<< 2) - fz_e - ((nz_e <<< 3) - nz_e);

    assign dx = signed'({far_x_reg[COORD_W-1], far_x_reg})
              - signed'({near_x_reg[COORD_W-1], near_x_reg});
    assign dz = signed'({far_z_reg[COORD_W-1], far_z_reg})
              - signed'({near_z_reg[COORD_W-1], near_z_reg});
    assign sqx_full = dx * dx;
    assign sqz_full = dz * dz;

    assign sq_sum  = {1'b0, sqx_reg} + {1'b0, sqz_reg};
    assign outside = (px_reg > lim_s) || (px_reg < -lim_s)
                  || (pz_reg > lim_s) || (pz_reg < -lim_s);
    assign ar      = pz_reg + lim_s;
    assign ac      = px_reg + lim_s;
    assign ac_m1   = ac[NUMW-1:0] - NUMW'(1);

    assign row_ge = (rrow_reg >= wsh_reg);
    assign col_ge = (rcol_reg >= wsh_reg);

    assign row_c = (qrow_reg > QW'(GRID_SIDE - 1)) ? CW'(GRID_SIDE - 1) : qrow_reg[CW-1:0];
    assign col_c = colz_reg ? '0 :
                   (qcol_reg > QW'(GRID_SIDE - 1)) ? CW'(GRID_SIDE - 1) : qcol_reg[CW-1:0];
    assign idx_full = CMPW'(row_c) * CMPW'(GRID_SIDE) + CMPW'(col_c);
    assign idx_ok   = (idx_full < CMPW'(BIN_TOTAL));

    assign qext = CMPW'(s_query_bin);
    assign q_ok = (qext < CMPW'(BIN_TOTAL));

    assign mem_sum   = mem_q_reg[ENTW-1:HITS_W];
    assign mem_hits  = mem_q_reg[HITS_W-1:0];
    assign sum_add   = {1'b0, mem_sum} + (SUM_W + 1)'(photons_reg);
    assign sum_next  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign hits_next = (mem_hits == '1) ? mem_hits : mem_hits + HITS_W'(1);

    assign m_ge = (rem_reg >= {1'b0, dsh_reg});

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {sum_next, hits_next};
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_LOAD && kind_reg != KIND_QUERY) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_full[AMW-1:0];
        if (state_reg == ST_IDLE && s_valid && s_kind == KIND_QUERY && q_ok) begin
            rd_en   = 1'b1;
            rd_addr = qext[AMW-1:0];
        end else if (state_reg == ST_INDEX && idx_ok) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_extent_reg   <= HALF_EXTENT_RST;
            bin_width_reg     <= BIN_WIDTH_RST;
            max_offset_sq_reg <= MAX_OFFSET_SQ_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HALF_EXTENT:   half_extent_reg   <= cfg_wdata[HALF_W-1:0];
                CFG_BIN_WIDTH:     bin_width_reg     <= cfg_wdata[BWID_W-1:0];
                CFG_MAX_OFFSET_SQ: max_offset_sq_reg <= cfg_wdata[OFFSQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AMW'(1);
                    if (clr_cnt_reg == AMW'(BIN_TOTAL - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg    <= s_kind;
                        near_x_reg  <= s_near_x;
                        near_z_reg  <= s_near_z;
                        far_x_reg   <= s_far_x;
                        far_z_reg   <= s_far_z;
                        photons_reg <= s_photons;
                        if (s_kind == KIND_QUERY) begin
                            res_outcome_reg <= OUT_OK;
                            res_bin_reg     <= s_query_bin;
                            if (q_ok) begin
                                idx_reg   <= qext[AMW-1:0];
                                state_reg <= ST_LOAD;
                            end else begin
                                res_mean_reg <= '0;
                                res_hits_reg <= '0;
                                state_reg    <= ST_FINISH;
                            end
                        end else begin
                            state_reg <= ST_CALC;
                        end
                    end
                end
                ST_CALC: begin
                    zero_reg  <= (near_x_reg == '0) && (near_z_reg == '0)
                              && (far_x_reg == '0) && (far_z_reg == '0);
                    sqx_reg   <= sqx_full[31:0];
                    sqz_reg   <= sqz_full[31:0];
                    px_reg    <= px_n;
                    pz_reg    <= pz_n;
                    state_reg <= ST_TEST;
                end
                ST_TEST: begin
                    res_bin_reg  <= '0;
                    res_mean_reg <= '0;
                    res_hits_reg <= '0;
                    if (zero_reg) begin
                        res_outcome_reg <= OUT_NO_TRACK;
                        state_reg       <= ST_FINISH;
                    end else if ({2'b0, sq_sum} > max_offset_sq_reg) begin
                        res_outcome_reg <= OUT_TOO_STEEP;
                        state_reg       <= ST_FINISH;
                    end else if (outside) begin
                        res_outcome_reg <= OUT_OUTSIDE;
                        state_reg       <= ST_FINISH;
                    end else begin
                        rrow_reg  <= {{(DIVW-NUMW){1'b0}}, ar[NUMW-1:0]};
                        rcol_reg  <= {{(DIVW-NUMW){1'b0}}, ac_m1};
                        colz_reg  <= (ac == '0);
                        wsh_reg   <= {1'b0, w20, {CW{1'b0}}};
                        qrow_reg  <= '0;
                        qcol_reg  <= '0;
                        cnt_reg   <= CNTW'(CW);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // The top quotient bit only flags a cell beyond the grid edge.
                    if (row_ge) begin
                        rrow_reg <= rrow_reg - wsh_reg;
                    end
                    if (col_ge) begin
                        rcol_reg <= rcol_reg - wsh_reg;
                    end
                    qrow_reg <= {qrow_reg[QW-2:0], row_ge};
                    qcol_reg <= {qcol_reg[QW-2:0], col_ge};
                    wsh_reg  <= wsh_reg >> 1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_INDEX;
                    end else begin
                        cnt_reg <= cnt_reg - CNTW'(1);
                    end
                end
                ST_INDEX: begin
                    if (idx_ok) begin
                        idx_reg         <= idx_full[AMW-1:0];
                        res_bin_reg     <= idx_full[BIN_W-1:0];
                        res_outcome_reg <= OUT_OK;
                        state_reg       <= ST_LOAD;
                    end else begin
                        res_outcome_reg <= OUT_OUTSIDE;
                        res_bin_reg     <= '0;
                        res_mean_reg    <= '0;
                        res_hits_reg    <= '0;
                        state_reg       <= ST_FINISH;
                    end
                end
                ST_LOAD: begin
                    if (kind_reg == KIND_QUERY) begin
                        sum_reg  <= mem_sum;
                        hits_reg <= mem_hits;
                    end else begin
                        sum_reg  <= sum_next;
                        hits_reg <= hits_next;
                    end
                    state_reg <= ST_MSETUP;
                end
                ST_MSETUP: begin
                    res_hits_reg <= hits_reg;
                    if (hits_reg == '0) begin
                        res_mean_reg <= '0;
                        state_reg    <= ST_FINISH;
                    end else if (sum_reg >= {hits_reg, {(MEAN_W-MEAN_FRAC_W){1'b0}}}) begin
                        res_mean_reg <= '1;
                        state_reg    <= ST_FINISH;
                    end else begin
                        rem_reg   <= {sum_reg, {MEAN_FRAC_W{1'b0}}};
                        dsh_reg   <= {hits_reg, {(MEAN_W-1){1'b0}}};
                        mcnt_reg  <= MCW'(MEAN_W - 1);
                        state_reg <= ST_MDIV;
                    end
                end
                ST_MDIV: begin
                    if (m_ge) begin
                        rem_reg <= rem_reg - {1'b0, dsh_reg};
                    end
                    res_mean_reg <= {res_mean_reg[MEAN_W-2:0], m_ge};
                    dsh_reg      <= dsh_reg >> 1;
                    mcnt_reg     <= mcnt_reg - MCW'(1);
                    if (mcnt_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_outcome_reg   <= res_outcome_reg;
                        m_bin_index_reg <= res_bin_reg;
                        m_mean_q8_reg   <= res_mean_reg;
                        m_hit_count_reg <= res_hits_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_reject_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_outcome_reg != OUT_OK) |->
            (m_bin_index_reg == '0) && (m_mean_q8_reg == '0) && (m_hit_count_reg == '0))
        else $error("rejected beat carries a nonzero bin payload");

    a_empty_bin_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_hit_count_reg == '0) |-> (m_mean_q8_reg == '0))
        else $error("empty bin reports a nonzero mean");

    a_mean_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MDIV) |-> (rem_reg < {dsh_reg, 1'b0}))
        else $error("mean divider remainder out of range");

    a_mem_port_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && rd_en))
        else $error("bin memory read and write in the same cycle");

endmodule
